FILE: sv/fixed_point_alu_top_defines.svh
// assertion helpers for the fixed-point alu
`ifndef FIXED_POINT_ALU_TOP_DEFINES_SVH
`define FIXED_POINT_ALU_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fpa_pkg.sv
package fpa_pkg;

    // default number of fraction bits (q24.8)
    localparam int FRAC_BITS_DEF = 8;

    // operation codes
    typedef enum logic [3:0] {
        MODE_ADD      = 4'd0,
        MODE_SUB      = 4'd1,
        MODE_MUL      = 4'd2,
        MODE_DIV      = 4'd3,
        MODE_MIN      = 4'd4,
        MODE_MAX      = 4'd5,
        MODE_FROM_INT = 4'd6,
        MODE_TO_INT   = 4'd7,
        MODE_INC      = 4'd8,
        MODE_DEC      = 4'd9
    } t_mode;

endpackage

FILE: sv/fixed_point_alu_top.sv
// signed 32-bit fixed-point alu, FRAC_BITS fraction bits
// input channel: i_valid / o_stall carry i_mode, i_operand_a, i_operand_b;
// a beat is taken on a rising edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall carry the result value, the compare
// flags and the divide-by-zero flag; a beat leaves on a rising edge with
// o_valid high and i_stall low. every input beat yields one output beat.
// depth: a result passes stage 0, the divide stages and the output
// register before it is presented. the depth is set by the restoring
// divider, one quotient bit per stage over the 32+FRAC_BITS bit dividend;
// the other operations ride along the same stages.
// throughput: one beat per cycle while the receiver takes results.
// when the receiver stalls with a result waiting, the whole pipeline
// freezes and o_stall rises; nothing is dropped or repeated, and empty
// slots inside the pipeline are not squeezed out.
// reset (synchronous, active low) clears every valid bit; the payload
// registers are not reset.
module fixed_point_alu_top #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_mode,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value,
    output logic               o_equal_flag,
    output logic               o_less_flag,
    output logic               o_greater_flag,
    output logic               o_divide_by_zero
);

`include "fixed_point_alu_top_defines.svh"

    // dividend width and number of divide stages
    localparam int          DW        = 32 + FRAC_BITS;
    localparam int          NS        = DW;
    localparam logic [31:0] FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;

    // pipeline enable: freeze everything while a result waits on a stall
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage registers
    logic [NS:0]        r_vld;
    logic [31:0]        r_res   [0:NS];
    logic [2:0]         r_cmp   [0:NS];
    logic               r_is_div[0:NS];
    logic               r_dz    [0:NS];
    logic               r_qneg  [0:NS];
    logic [31:0]        r_dv    [0:NS];
    logic [31:0]        r_rem   [0:NS];
    logic [DW-1:0]      r_dd    [0:NS];
    logic               r_is_mul0;
    logic               r_is_mul1;
    logic signed [31:0] r_mul_a;
    logic signed [31:0] r_mul_b;
    logic signed [63:0] r_prod;

    // output register
    logic               r_out_vld;
    logic signed [31:0] r_out_res;
    logic [2:0]         r_out_cmp;
    logic               r_out_dz;

    // input decode
    fpa_pkg::t_mode     w_mode;
    logic               w_eq;
    logic               w_lt;
    logic               w_gt;
    logic [31:0]        w_abs_a;
    logic [31:0]        w_abs_b;
    logic [DW-1:0]      w_dd0;
    logic [31:0]        w_bias;
    logic signed [31:0] w_to_int_sum;
    logic [31:0]        n_res0;

    always_comb begin
        w_mode       = fpa_pkg::t_mode'(i_mode);
        w_eq         = (i_operand_a == i_operand_b);
        w_lt         = (i_operand_a < i_operand_b);
        w_gt         = (i_operand_a > i_operand_b);
        w_abs_a      = i_operand_a[31] ? (~i_operand_a + 32'd1) : i_operand_a;
        w_abs_b      = i_operand_b[31] ? (~i_operand_b + 32'd1) : i_operand_b;
        w_dd0        = DW'(w_abs_a) << FRAC_BITS;
        w_bias       = i_operand_a[31] ? FRAC_MASK : 32'd0;
        w_to_int_sum = i_operand_a + $signed(w_bias);
        unique case (w_mode)
            fpa_pkg::MODE_ADD:      n_res0 = i_operand_a + i_operand_b;
            fpa_pkg::MODE_SUB:      n_res0 = i_operand_a - i_operand_b;
            fpa_pkg::MODE_MIN:      n_res0 = w_lt ? i_operand_a : i_operand_b;
            fpa_pkg::MODE_MAX:      n_res0 = w_gt ? i_operand_a : i_operand_b;
            fpa_pkg::MODE_FROM_INT: n_res0 = i_operand_a <<< FRAC_BITS;
            fpa_pkg::MODE_TO_INT:   n_res0 = w_to_int_sum >>> FRAC_BITS;
            fpa_pkg::MODE_INC:      n_res0 = i_operand_a + 32'sd1;
            fpa_pkg::MODE_DEC:      n_res0 = i_operand_a - 32'sd1;
            default:                n_res0 = 32'd0;
        endcase
    end

    // one restoring divide step per stage
    logic [32:0]   w_trial [0:NS-1];
    logic          w_ge    [0:NS-1];
    logic [32:0]   w_diff  [0:NS-1];
    logic [31:0]   n_rem   [1:NS];
    logic [DW-1:0] n_dd    [1:NS];

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_trial[k]  = {r_rem[k], r_dd[k][DW-1]};
            w_diff[k]   = w_trial[k] - {1'b0, r_dv[k]};
            w_ge[k]     = (w_trial[k] >= {1'b0, r_dv[k]});
            n_rem[k+1]  = w_ge[k] ? w_diff[k][31:0] : w_trial[k][31:0];
            n_dd[k+1]   = {r_dd[k][DW-2:0], w_ge[k]};
        end
    end

    // final select: signed quotient (zero on divide by zero), product or ride-along result
    logic [31:0] w_quot;
    logic [31:0] n_out_res;

    always_comb begin
        w_quot = r_dd[NS][31:0];
        if (r_is_div[NS]) begin
            if (r_dz[NS]) begin
                n_out_res = 32'd0;
            end else begin
                n_out_res = r_qneg[NS] ? (~w_quot + 32'd1) : w_quot;
            end
        end else begin
            n_out_res = r_res[NS];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[NS-1:0], i_valid};
            r_out_vld <= r_vld[NS];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 0: decoded operands
            r_res[0]    <= n_res0;
            r_cmp[0]    <= {w_eq, w_lt, w_gt};
            r_is_div[0] <= (w_mode == fpa_pkg::MODE_DIV);
            r_dz[0]     <= (w_mode == fpa_pkg::MODE_DIV) && (i_operand_b == 32'sd0);
            r_qneg[0]   <= i_operand_a[31] ^ i_operand_b[31];
            r_dv[0]     <= w_abs_b;
            r_rem[0]    <= 32'd0;
            r_dd[0]     <= w_dd0;
            r_is_mul0   <= (w_mode == fpa_pkg::MODE_MUL);
            r_mul_a     <= i_operand_a;
            r_mul_b     <= i_operand_b;

            // multiply in stage 1, scaled slice lands in stage 2
            r_prod      <= r_mul_a * r_mul_b;
            r_is_mul1   <= r_is_mul0;

            // divide stages
            for (int k = 0; k < NS; k++) begin
                r_cmp[k+1]    <= r_cmp[k];
                r_is_div[k+1] <= r_is_div[k];
                r_dz[k+1]     <= r_dz[k];
                r_qneg[k+1]   <= r_qneg[k];
                r_dv[k+1]     <= r_dv[k];
                r_rem[k+1]    <= n_rem[k+1];
                r_dd[k+1]     <= n_dd[k+1];
                if (k == 1) begin
                    r_res[k+1] <= r_is_mul1 ? r_prod[FRAC_BITS +: 32] : r_res[k];
                end else begin
                    r_res[k+1] <= r_res[k];
                end
            end

            // output register
            r_out_res <= n_out_res;
            r_out_cmp <= r_cmp[NS];
            r_out_dz  <= r_dz[NS];
        end
    end

    assign o_valid          = r_out_vld;
    assign o_result_value   = r_out_res;
    assign o_equal_flag     = r_out_cmp[2];
    assign o_less_flag      = r_out_cmp[1];
    assign o_greater_flag   = r_out_cmp[0];
    assign o_divide_by_zero = r_out_dz;

    // checks
    `FPA_ASSERT_NOW(a_dz_gives_zero, o_valid && o_divide_by_zero, o_result_value == 32'sd0, "divide by zero result not zero")
    `FPA_ASSERT_NOW(a_cmp_onehot, o_valid, $onehot({o_equal_flag, o_less_flag, o_greater_flag}), "compare flags not one-hot")
    `FPA_ASSERT_NEXT(a_stall_freezes, o_valid && i_stall, $stable(r_vld) && $stable(o_result_value), "pipeline moved while stalled")
    `FPA_ASSERT_NEXT(a_beat_enters, i_valid && !o_stall, r_vld[0], "accepted beat not in first stage")

endmodule
